### design/prf_pkg.sv
// Package for the primitive root finder: field widths and small shared constants.
// Depends on nothing; imported by the top level and the testbench.
package prf_pkg;

  // Width of the modulus, root and count ports
  localparam int FIELD_W = 31;

  // Smallest modulus that runs a search
  localparam int MIN_MODULUS = 2;

  // First candidate divisor and first candidate generator
  localparam int FIRST_TRIAL = 2;

endpackage

### design/prf_divider.sv
// Shared restoring divider for the primitive root finder: one quotient bit per cycle.
// Short requests divide a W-bit value, long requests a 2W-bit value.
// Depends on nothing outside this file.
module prf_divider #(
  parameter int W = 31
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           long_mode,
  input  logic [2*W-1:0] dividend,
  input  logic [W-1:0]   divisor,
  output logic           done,
  output logic [2*W-1:0] quotient,
  output logic [W-1:0]   remainder
);

  localparam int CNT_W = $clog2(2 * W + 1);

  logic [2*W-1:0] dvd_r, dvd_nxt;
  logic [W-1:0]   rem_r, rem_nxt;
  logic [W-1:0]   dsr_r, dsr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;
  logic [W:0]     trial;
  logic [W:0]     diff;

  // Form one trial subtraction
  assign trial = {rem_r, dvd_r[2*W-1]};
  assign diff  = trial - {1'b0, dsr_r};

  // Load a request or advance one quotient bit
  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt  = long_mode ? dividend : {dividend[W-1:0], {W{1'b0}}};
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      cnt_nxt  = long_mode ? CNT_W'(2 * W) : CNT_W'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[W]) begin
        rem_nxt = diff[W-1:0];
        dvd_nxt = {dvd_r[2*W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[W-1:0];
        dvd_nxt = {dvd_r[2*W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done      = done_r;
  assign quotient  = dvd_r;
  assign remainder = rem_r;

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("divider done held longer than one cycle");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("divider done without a running division");
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (rem_r < dsr_r)) else $error("divider remainder not below divisor");

endmodule

### design/primitive_root_finder.sv
// Primitive root finder, top level: sequencer, factor list and the shared multiplier.
// Depends on prf_pkg and prf_divider.
//
// Pulse start while busy is low to hand in one modulus n; busy then stays high until
// the result appears. out_valid is high for exactly one cycle with the smallest
// primitive root and the totient of n-1; the receiver cannot hold it off, so capture
// it in that cycle. Every division and modular reduction goes through one restoring
// divider, one bit per cycle, next to one multiplier. Factoring n-1 tries each trial
// divisor up to the square root of what is left of n-1. The exponentiations use one
// or two modular multiplies per exponent bit per prime factor per candidate.
// A modulus below two is answered in the cycle after the request without going busy.
module primitive_root_finder
  import prf_pkg::*;
#(
  parameter int MODULUS_BITS = 31,
  parameter int MAX_FACTORS  = 9
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [FIELD_W-1:0] in_prime_modulus,
  output logic               out_valid,
  output logic [FIELD_W-1:0] out_primitive_root,
  output logic [FIELD_W-1:0] out_root_count
);

  localparam int W    = MODULUS_BITS;
  localparam int DW   = (W + 1) / 2 + 1;
  localparam int SW   = W + 2;
  localparam int CW   = $clog2(MAX_FACTORS + 1);
  localparam int IW   = $clog2(MAX_FACTORS);

  typedef enum logic [3:0] {
    S_IDLE, S_TCHK, S_TDIV, S_TNEXT, S_KEEP, S_KDIV, S_GINIT, S_GCHK,
    S_QCHK, S_EDIV, S_PSTEP, S_MULA, S_MDA, S_MULB, S_MDB
  } state_t;

  state_t          state_r, state_nxt;
  logic [W-1:0]    n_r, n_nxt;
  logic [W-1:0]    m_r, m_nxt;
  logic [W-1:0]    rest_r, rest_nxt;
  logic [W-1:0]    tot_r, tot_nxt;
  logic [DW-1:0]   d_r, d_nxt;
  logic [SW-1:0]   sq_r, sq_nxt;
  logic            found_r, found_nxt;
  logic            last_r, last_nxt;
  logic [W-1:0]    p_r, p_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [CW-1:0]   k_r, k_nxt;
  logic [W-1:0]    g_r, g_nxt;
  logic [W-1:0]    exp_r, exp_nxt;
  logic [W-1:0]    acc_r, acc_nxt;
  logic [W-1:0]    base_r, base_nxt;
  logic [2*W-1:0]  prod_r, prod_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [FIELD_W-1:0] out_root_r, out_root_nxt;
  logic [FIELD_W-1:0] out_count_r, out_count_nxt;

  logic [W-1:0]    factor_mem [MAX_FACTORS];
  logic            list_we;
  logic [W-1:0]    q_rd_r;
  logic [W-1:0]    in_n;

  logic            div_start;
  logic            div_long;
  logic [2*W-1:0]  div_dividend;
  logic [W-1:0]    div_divisor;
  logic            div_done;
  logic [2*W-1:0]  div_quot;
  logic [W-1:0]    div_rem;
  logic [W-1:0]    quot_lo;

  logic [W-1:0]    mul_a;
  logic [W-1:0]    mul_b;
  logic [2*W-1:0]  prod;

  prf_divider #(.W(W)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .long_mode (div_long),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  assign in_n    = in_prime_modulus[W-1:0];
  assign quot_lo = div_quot[W-1:0];
  assign prod    = mul_a * mul_b;

  // Sequence factoring, totient update and candidate search
  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    m_nxt         = m_r;
    rest_nxt      = rest_r;
    tot_nxt       = tot_r;
    d_nxt         = d_r;
    sq_nxt        = sq_r;
    found_nxt     = found_r;
    last_nxt      = last_r;
    p_nxt         = p_r;
    cnt_nxt       = cnt_r;
    k_nxt         = k_r;
    g_nxt         = g_r;
    exp_nxt       = exp_r;
    acc_nxt       = acc_r;
    base_nxt      = base_r;
    prod_nxt      = prod_r;
    out_valid_nxt = 1'b0;
    out_root_nxt  = out_root_r;
    out_count_nxt = out_count_r;
    list_we       = 1'b0;
    div_start     = 1'b0;
    div_long      = 1'b0;
    div_dividend  = {{W{1'b0}}, rest_r};
    div_divisor   = W'(d_r);
    mul_a         = acc_r;
    mul_b         = base_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          cnt_nxt = '0;
          n_nxt   = in_n;
          if (in_n < W'(MIN_MODULUS)) begin
            out_root_nxt  = '0;
            out_count_nxt = '0;
            out_valid_nxt = 1'b1;
          end else begin
            m_nxt     = in_n - W'(1);
            rest_nxt  = in_n - W'(1);
            tot_nxt   = in_n - W'(1);
            d_nxt     = DW'(FIRST_TRIAL);
            sq_nxt    = SW'(FIRST_TRIAL * FIRST_TRIAL);
            found_nxt = 1'b0;
            state_nxt = S_TCHK;
          end
        end
      end
      S_TCHK: begin
        if (sq_r <= SW'(rest_r)) begin
          div_start = 1'b1;
          state_nxt = S_TDIV;
        end else if (rest_r > W'(1)) begin
          p_nxt     = rest_r;
          last_nxt  = 1'b1;
          state_nxt = S_KEEP;
        end else begin
          state_nxt = S_GINIT;
        end
      end
      S_TDIV: begin
        if (div_done) begin
          if (div_rem == '0) begin
            // Strip this divisor again from what is left
            found_nxt    = 1'b1;
            rest_nxt     = quot_lo;
            div_dividend = {{W{1'b0}}, quot_lo};
            div_start    = 1'b1;
          end else if (found_r) begin
            p_nxt     = W'(d_r);
            last_nxt  = 1'b0;
            state_nxt = S_KEEP;
          end else begin
            state_nxt = S_TNEXT;
          end
        end
      end
      S_TNEXT: begin
        d_nxt     = d_r + DW'(1);
        sq_nxt    = sq_r + SW'({d_r, 1'b1});
        found_nxt = 1'b0;
        state_nxt = S_TCHK;
      end
      S_KEEP: begin
        if (cnt_r < CW'(MAX_FACTORS)) begin
          list_we = 1'b1;
          cnt_nxt = cnt_r + CW'(1);
        end
        div_dividend = {{W{1'b0}}, tot_r};
        div_divisor  = p_r;
        div_start    = 1'b1;
        state_nxt    = S_KDIV;
      end
      S_KDIV: begin
        if (div_done) begin
          mul_a     = quot_lo;
          mul_b     = p_r - W'(1);
          tot_nxt   = prod[W-1:0];
          state_nxt = last_r ? S_GINIT : S_TNEXT;
        end
      end
      S_GINIT: begin
        g_nxt     = W'(FIRST_TRIAL);
        state_nxt = S_GCHK;
      end
      S_GCHK: begin
        if (g_r < m_r) begin
          k_nxt     = '0;
          state_nxt = S_QCHK;
        end else begin
          out_root_nxt  = FIELD_W'(m_r);
          out_count_nxt = FIELD_W'(tot_r);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_QCHK: begin
        if (k_r < cnt_r) begin
          div_dividend = {{W{1'b0}}, m_r};
          div_divisor  = q_rd_r;
          div_start    = 1'b1;
          state_nxt    = S_EDIV;
        end else begin
          out_root_nxt  = FIELD_W'(g_r);
          out_count_nxt = FIELD_W'(tot_r);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_EDIV: begin
        if (div_done) begin
          exp_nxt   = quot_lo;
          acc_nxt   = W'(1);
          base_nxt  = g_r;
          state_nxt = S_PSTEP;
        end
      end
      S_PSTEP: begin
        if (exp_r == '0) begin
          if (acc_r == W'(1)) begin
            g_nxt     = g_r + W'(1);
            state_nxt = S_GCHK;
          end else begin
            k_nxt     = k_r + CW'(1);
            state_nxt = S_QCHK;
          end
        end else if (exp_r[0]) begin
          prod_nxt  = prod;
          state_nxt = S_MULA;
        end else begin
          mul_a     = base_r;
          prod_nxt  = prod;
          state_nxt = S_MULB;
        end
      end
      S_MULA: begin
        div_dividend = prod_r;
        div_divisor  = n_r;
        div_long     = 1'b1;
        div_start    = 1'b1;
        state_nxt    = S_MDA;
      end
      S_MDA: begin
        if (div_done) begin
          acc_nxt   = div_rem;
          mul_a     = base_r;
          prod_nxt  = prod;
          state_nxt = S_MULB;
        end
      end
      S_MULB: begin
        div_dividend = prod_r;
        div_divisor  = n_r;
        div_long     = 1'b1;
        div_start    = 1'b1;
        state_nxt    = S_MDB;
      end
      S_MDB: begin
        if (div_done) begin
          base_nxt  = div_rem;
          exp_nxt   = exp_r >> 1;
          state_nxt = S_PSTEP;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state, datapath and the result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
    n_r         <= n_nxt;
    m_r         <= m_nxt;
    rest_r      <= rest_nxt;
    tot_r       <= tot_nxt;
    d_r         <= d_nxt;
    sq_r        <= sq_nxt;
    found_r     <= found_nxt;
    last_r      <= last_nxt;
    p_r         <= p_nxt;
    k_r         <= k_nxt;
    g_r         <= g_nxt;
    exp_r       <= exp_nxt;
    acc_r       <= acc_nxt;
    base_r      <= base_nxt;
    prod_r      <= prod_nxt;
    out_root_r  <= out_root_nxt;
    out_count_r <= out_count_nxt;
  end

  // Store a new distinct prime factor; fetch the factor for the next test
  always_ff @(posedge clk) begin
    if (list_we) begin
      factor_mem[cnt_r[IW-1:0]] <= p_r;
    end
    q_rd_r <= factor_mem[k_nxt[IW-1:0]];
  end

  assign busy               = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_primitive_root = out_root_r;
  assign out_root_count     = out_count_r;

  a_valid_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result shown while still busy");
  a_valid_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !start) |=> !out_valid)
    else $error("result strobe longer than one cycle without a new request");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_n >= W'(MIN_MODULUS))) |=> busy)
    else $error("request accepted without going busy");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_FACTORS)) else $error("factor count beyond list depth");

endmodule

### dv/primitive_root_finder_tb.sv
// Testbench for primitive_root_finder: drives moduli through the start/busy port and
// checks each strobed result against typed values or a root and totient predictor.
// Depends on prf_pkg and the primitive_root_finder RTL.
`timescale 1ns / 100ps

module primitive_root_finder_tb;
  import prf_pkg::*;

  localparam int  MAX_FACTORS = 9;
  localparam int  RANDOM_ITEMS = 80;
  localparam int  END_WAIT = 200;
  localparam longint CYCLE_LIMIT = 40_000_000;

  typedef struct {
    logic [FIELD_W-1:0] root;
    logic [FIELD_W-1:0] count;
  } root_result_t;

  typedef struct {
    logic [FIELD_W-1:0] modulus;
    bit                 typed;
    logic [FIELD_W-1:0] root;
    logic [FIELD_W-1:0] count;
  } stim_row_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [FIELD_W-1:0] in_prime_modulus;
  logic               out_valid;
  logic [FIELD_W-1:0] out_primitive_root;
  logic [FIELD_W-1:0] out_root_count;

  root_result_t       pending_roots[$];
  logic [FIELD_W-1:0] modulus_queue[$];
  root_result_t       typed_queue[$];
  bit                 typed_flag_queue[$];
  int                 error_count = 0;
  longint             cycle_count = 0;

  primitive_root_finder DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_prime_modulus(in_prime_modulus), .out_valid(out_valid),
    .out_primitive_root(out_primitive_root), .out_root_count(out_root_count)
  );

  // 2 ns clock
  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  task automatic report_mismatch(input string what, input logic [FIELD_W-1:0] got,
                                 input logic [FIELD_W-1:0] want);
    $display("mismatch %s: got %0d, want %0d (cycle %0d)", what, got, want, cycle_count);
    error_count++;
  endtask

  function automatic longint unsigned mod_power(longint unsigned base, longint unsigned ex,
                                                longint unsigned md);
    longint unsigned acc;
    acc = 1 % md;
    base = base % md;
    while (ex > 0) begin
      if (ex[0]) acc = (acc * base) % md;
      ex = ex >> 1;
      base = (base * base) % md;
    end
    return acc;
  endfunction

  // Factor n-1, count its generators, then search for the smallest root
  function automatic root_result_t predict_root(logic [FIELD_W-1:0] modulus);
    root_result_t    res;
    longint unsigned n, m, rest, d, tot, g, root;
    longint unsigned factors[MAX_FACTORS];
    int              nfac;
    bit              pass;
    n = 64'(modulus);
    nfac = 0;
    if (n < MIN_MODULUS) begin
      res.root = '0;
      res.count = '0;
      return res;
    end
    m = n - 1;
    rest = m;
    tot = m;
    for (d = FIRST_TRIAL; d * d <= rest; d++) begin
      if (rest % d == 0) begin
        while (rest % d == 0) rest = rest / d;
        if (nfac < MAX_FACTORS) begin
          factors[nfac] = d;
          nfac++;
        end
        tot = (tot / d) * (d - 1);
      end
    end
    if (rest > 1) begin
      if (nfac < MAX_FACTORS) begin
        factors[nfac] = rest;
        nfac++;
      end
      tot = (tot / rest) * (rest - 1);
    end
    root = m;
    for (g = FIRST_TRIAL; g < m; g++) begin
      pass = 1'b1;
      for (int k = 0; k < nfac; k++) begin
        if (mod_power(g, m / factors[k], n) == 1) begin
          pass = 1'b0;
          break;
        end
      end
      if (pass) begin
        root = g;
        break;
      end
    end
    res.root = root[FIELD_W-1:0];
    res.count = tot[FIELD_W-1:0];
    return res;
  endfunction

  function automatic bit is_prime(int unsigned v);
    if (v < 2) return 1'b0;
    for (int unsigned d = 2; d * d <= v; d++) if (v % d == 0) return 1'b0;
    return 1'b1;
  endfunction

  // Mostly small primes, some composites and noise, a few wider primes
  function automatic logic [FIELD_W-1:0] random_modulus();
    int unsigned v;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) return FIELD_W'($urandom_range(0, 4095));
    v = (pick < 95) ? $urandom_range(3, 4095) : $urandom_range(4096, 1 << 20);
    while (!is_prime(v)) v++;
    return FIELD_W'(v);
  endfunction

  // Directed rows: typed expectations where obvious, predictor elsewhere
  stim_row_t directed[] = '{
    '{31'd0,          1'b1, 31'd0, 31'd0},
    '{31'd1,          1'b1, 31'd0, 31'd0},
    '{31'd2,          1'b1, 31'd1, 31'd1},
    '{31'd3,          1'b1, 31'd2, 31'd1},
    '{31'd5,          1'b0, 31'd0, 31'd0},
    '{31'd7,          1'b0, 31'd0, 31'd0},
    '{31'd11,         1'b0, 31'd0, 31'd0},
    '{31'd13,         1'b0, 31'd0, 31'd0},
    '{31'd17,         1'b0, 31'd0, 31'd0},
    '{31'd23,         1'b0, 31'd0, 31'd0},
    '{31'd41,         1'b0, 31'd0, 31'd0},
    '{31'd191,        1'b0, 31'd0, 31'd0},
    '{31'd257,        1'b0, 31'd0, 31'd0},
    '{31'd4,          1'b0, 31'd0, 31'd0},
    '{31'd9,          1'b0, 31'd0, 31'd0},
    '{31'd15,         1'b0, 31'd0, 31'd0},
    '{31'd21,         1'b0, 31'd0, 31'd0},
    '{31'd4093,       1'b0, 31'd0, 31'd0},
    '{31'd65537,      1'b0, 31'd0, 31'd0},
    '{31'h40000001,   1'b0, 31'd0, 31'd0},
    '{31'h7FFFFFFF,   1'b0, 31'd0, 31'd0}
  };

  // Check each strobed result against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_roots.size() == 0) begin
        report_mismatch("unexpected result root", out_primitive_root, '0);
      end else begin
        root_result_t want;
        want = pending_roots.pop_front();
        if (out_primitive_root !== want.root)
          report_mismatch("primitive_root", out_primitive_root, want.root);
        if (out_root_count !== want.count)
          report_mismatch("root_count", out_root_count, want.count);
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL primitive_root_finder");
      $finish;
    end
  end

  initial begin
    int total;
    int idx;
    int quiet_lo;
    int quiet_hi;
    root_result_t exp_r;
    start = 1'b0;
    in_prime_modulus = '0;
    rst_n = 1'b0;
    foreach (directed[i]) begin
      modulus_queue = {modulus_queue, directed[i].modulus};
      typed_flag_queue = {typed_flag_queue, directed[i].typed};
      exp_r.root = directed[i].root;
      exp_r.count = directed[i].count;
      typed_queue = {typed_queue, exp_r};
    end
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      modulus_queue = {modulus_queue, random_modulus()};
      typed_flag_queue = {typed_flag_queue, 1'b0};
      typed_queue = {typed_queue, exp_r};
    end
    total = modulus_queue.size();
    quiet_lo = directed.size() + 30;
    quiet_hi = quiet_lo + 30;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the request list; hold start until busy drops
    idx = 0;
    while (idx < total) begin
      @(posedge clk);
      if (start && !busy) begin
        if (typed_flag_queue[idx]) exp_r = typed_queue[idx];
        else exp_r = predict_root(modulus_queue[idx]);
        pending_roots = {pending_roots, exp_r};
        idx++;
      end
      if (!(start && busy)) begin
        if (idx < total && ((idx >= quiet_lo && idx < quiet_hi) ||
                            $urandom_range(0, 99) >= 35)) begin
          start <= 1'b1;
          in_prime_modulus <= modulus_queue[idx];
        end else begin
          start <= 1'b0;
          in_prime_modulus <= FIELD_W'($urandom);
        end
      end
    end
    start <= 1'b0;

    // Drain outstanding results, then let the block settle
    while (pending_roots.size() > 0) @(posedge clk);
    repeat (END_WAIT) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS primitive_root_finder");
    end else begin
      $display("FAIL primitive_root_finder");
    end
    $finish;
  end

endmodule
